>>> sv/sst_pkg.sv
// sst_pkg: widths, codes, state type and small helpers for the score statistic block
// no dependencies
`default_nettype none

package sst_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);
  localparam int FAC_AW    = 2 * IDX_W;
  localparam int COL_DEPTH = MAX_ORDER + 1;
  localparam int COL_AW    = $clog2(COL_DEPTH);
  localparam int WORK_W    = 48;

  localparam int DIV_NUM_W = 96;
  localparam int DIV_DEN_W = 64;
  localparam int QUO_W     = 48;
  localparam int MUL_W     = 48;
  localparam int PROD_W    = 2 * MUL_W;

  localparam logic [QUO_W-1:0]  WMAX    = 48'h7FFF_FFFF_FFFF;
  localparam logic [QUO_W-1:0]  Q_LIM   = 48'h0000_7FFF_FFFF;
  localparam logic [63:0]       SUM_LIM = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_FACTOR = 2'd0,
    OP_LOAD_COLUMN = 2'd1,
    OP_COMPUTE     = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_ZERO_GRAD  = 3'd1,
    ERR_BAD_H22    = 3'd2,
    ERR_BAD_DEN    = 3'd3,
    ERR_ZERO_PIVOT = 3'd4
  } err_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_H_CHK,
    ST_SQRT,
    ST_V_RD,
    ST_V_GO,
    ST_V_DIV,
    ST_F_RD,
    ST_F_GO,
    ST_F_MUL,
    ST_U_DIV,
    ST_N_RD,
    ST_N_GO,
    ST_N_MUL,
    ST_DEN,
    ST_G_MUL,
    ST_HD_MUL,
    ST_Q_DIV,
    ST_DONE
  } state_e;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    mag48 = v[47] ? (48'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

`default_nettype wire

>>> sv/sst_div.sv
// sst_div: restoring divider, one quotient bit per cycle, quotient capped at a limit
// depends on sst_pkg
`default_nettype none

module sst_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sst_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [sst_pkg::DIV_DEN_W-1:0] den_i,
  input  wire logic [sst_pkg::QUO_W-1:0]     limit_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [sst_pkg::QUO_W-1:0]          quo_o
);
  import sst_pkg::*;

  localparam int DCNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DCNT_W-1:0]    cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] nq_q, nq_d;
  logic [QUO_W-1:0]     q_q, q_d;
  logic                 ovf_q, ovf_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [QUO_W-1:0]     lim_q, lim_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh = {rem_q, nq_q[DIV_NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nq_d   = nq_q;
    q_d    = q_q;
    ovf_d  = ovf_q;
    den_d  = den_q;
    lim_d  = lim_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      nq_d   = num_i;
      q_d    = '0;
      ovf_d  = 1'b0;
      den_d  = den_i;
      lim_d  = limit_i;
    end else if (busy_q) begin
      rem_d = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      nq_d  = {nq_q[DIV_NUM_W-2:0], 1'b0};
      q_d   = {q_q[QUO_W-2:0], fits};
      ovf_d = ovf_q | q_q[QUO_W-1];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
    den_q <= den_d;
    lim_q <= lim_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = (ovf_q || (q_q > lim_q)) ? lim_q : q_q;

endmodule

`default_nettype wire

>>> sv/sst_mul.sv
// sst_mul: 48x48 unsigned multiplier that accumulates one 24x24 partial product per cycle
// depends on sst_pkg
`default_nettype none

module sst_mul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sst_pkg::MUL_W-1:0]  a_i,
  input  wire logic [sst_pkg::MUL_W-1:0]  b_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [sst_pkg::PROD_W-1:0]      prod_o
);
  import sst_pkg::*;

  localparam int HALF = MUL_W / 2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [1:0]        k_q, k_d;
  logic [MUL_W-1:0]  a_q, a_d, b_q, b_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [HALF-1:0]   a_part, b_part;
  logic [MUL_W-1:0]  pp;
  logic [PROD_W-1:0] pp_sh;

  always_comb begin
    a_part = k_q[1] ? a_q[MUL_W-1:HALF] : a_q[HALF-1:0];
    b_part = k_q[0] ? b_q[MUL_W-1:HALF] : b_q[HALF-1:0];
    pp     = a_part * b_part;
    unique case (k_q)
      2'd0:    pp_sh = {{MUL_W{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {MUL_W{1'b0}}};
      default: pp_sh = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
    endcase
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      k_d   = k_q + 1'b1;
      if (k_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> sv/score_statistic_triangular_solve.sv
// score_statistic_triangular_solve: top level, stores, sequencer and square root
// depends on sst_pkg, sst_div, sst_mul
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_we_i               cfg_wdata_i (order n)
//  in        in         in_valid_i/in_stall_o  opcode, row_index, col_index, operand_value
//  out       out        out_valid_o/out_stall_i q_statistic, denominator, error_code
//
// load transactions can arrive back to back while no compute transaction is in progress
// a compute transaction keeps the block busy until its result is registered, ending
// early on an error; it uses the 96-step shared divider, the shared multiplier
// and the 32-step square root
// in_stall_o is high from a compute transaction until its result sits in the output register
// the output register lets the next transaction in while a result waits
// reset clears control state only; the stores need no clearing
`default_nettype none

module score_statistic_triangular_solve (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [4:0]  row_index_i,
  input  wire logic [3:0]  col_index_i,
  input  wire logic signed [31:0] operand_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [30:0]      q_statistic_o,
  output logic signed [31:0] denominator_o,
  output logic [2:0]       error_code_o
);
  import sst_pkg::*;

  // stores
  logic [31:0]       fac_mem [MAX_ORDER*MAX_ORDER];
  logic [31:0]       col_mem [COL_DEPTH];
  logic [WORK_W-1:0] wrk_mem [MAX_ORDER];

  logic [31:0]       fac_rd_q, col_rd_q;
  logic [WORK_W-1:0] wrk_rd_q;
  logic [FAC_AW-1:0] fac_raddr;
  logic [COL_AW-1:0] col_raddr;
  logic [IDX_W-1:0]  wrk_raddr, wrk_waddr;
  logic              wrk_we;
  logic [WORK_W-1:0] wrk_wdata;

  // control and datapath registers
  state_e            state_q, state_d;
  logic [4:0]        dim_q;
  logic [CNT_W-1:0]  n_q, n_d, i_q, i_d, j_q, j_d;
  logic [31:0]       g_q, g_d, h_q, h_d, r_q, r_d;
  logic [63:0]       sum_q, sum_d, gg_q, gg_d;
  logic [32:0]       d32_q, d32_d;
  logic              neg_q, neg_d;
  logic [63:0]       sq_x_q, sq_x_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [4:0]        sq_cnt_q, sq_cnt_d;
  logic [30:0]       res_q_q, res_q_d;
  logic [31:0]       res_den_q, res_den_d;
  err_e              res_err_q, res_err_d;
  logic              out_valid_q, out_valid_d;
  logic [30:0]       out_q_q, out_q_d;
  logic [31:0]       out_den_q, out_den_d;
  err_e              out_err_q, out_err_d;

  // shared units
  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [QUO_W-1:0]     div_lim, div_quo;
  logic                 mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_prod;

  // helpers
  logic              accept;
  logic [CNT_W-1:0]  n_cfg;
  logic [63:0]       sq_trial;
  logic [63:0]       t_mag, t_sgn, acc_sum, num_s, d32_s, den_sh;
  logic [31:0]       den_clip;
  logic              fac_ok, col_ok;

  sst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .limit_i (div_lim),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  sst_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign n_cfg      = (dim_q > 5'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(dim_q);

  // load writes go straight into the stores, out-of-range loads are dropped
  assign fac_ok = (row_index_i < 5'(MAX_ORDER)) && ({1'b0, col_index_i} < 5'(MAX_ORDER));
  assign col_ok = (row_index_i <= 5'(MAX_ORDER));

  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == OP_LOAD_FACTOR && fac_ok) begin
      fac_mem[{row_index_i[IDX_W-1:0], col_index_i[IDX_W-1:0]}] <= operand_value_i;
    end
    fac_rd_q <= fac_mem[fac_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == OP_LOAD_COLUMN && col_ok) begin
      col_mem[row_index_i] <= operand_value_i;
    end
    col_rd_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wrk_we) begin
      wrk_mem[wrk_waddr] <= wrk_wdata;
    end
    wrk_rd_q <= wrk_mem[wrk_raddr];
  end

  // read addresses: h22 sits at index n, the rest follow the loop counters
  assign col_raddr = (state_q == ST_IDLE) ? COL_AW'(n_cfg) : COL_AW'(i_q);
  assign fac_raddr = {i_q[IDX_W-1:0], j_q[IDX_W-1:0]};
  assign wrk_raddr = (state_q == ST_N_RD) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign wrk_waddr = i_q[IDX_W-1:0];

  always_comb begin
    // square root step: trial subtraction on one bit pair of the radicand
    sq_trial = sq_res_q + sq_bit_q;
    // product term of the current multiply, shifted and capped
    if (state_q == ST_N_MUL) begin
      t_mag = (mul_prod[PROD_W-1:32] > SUM_LIM) ? SUM_LIM : mul_prod[95:32];
    end else begin
      t_mag = (mul_prod[PROD_W-1:16] > {16'd0, SUM_LIM}) ? SUM_LIM : mul_prod[79:16];
    end
    t_sgn   = neg_q ? (64'd0 - t_mag) : t_mag;
    acc_sum = sum_q + ((state_q == ST_N_MUL) ? t_mag : t_sgn);
    num_s   = {{(64-WORK_W){wrk_rd_q[WORK_W-1]}}, wrk_rd_q} - sum_q;
    d32_s   = 64'h0000_0001_0000_0000 - sum_q;
    den_sh  = {{16{d32_s[63]}}, d32_s[63:16]};
    den_clip = ($signed(den_sh) < -64'sd2147483648) ? 32'h8000_0000 : den_sh[31:0];

    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    g_d       = g_q;
    h_d       = h_q;
    r_d       = r_q;
    sum_d     = sum_q;
    gg_d      = gg_q;
    d32_d     = d32_q;
    neg_d     = neg_q;
    sq_x_d    = sq_x_q;
    sq_res_d  = sq_res_q;
    sq_bit_d  = sq_bit_q;
    sq_cnt_d  = sq_cnt_q;
    res_q_d   = res_q_q;
    res_den_d = res_den_q;
    res_err_d = res_err_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_lim   = WMAX;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    wrk_we    = 1'b0;
    wrk_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && opcode_i == OP_COMPUTE) begin
          n_d       = n_cfg;
          g_d       = operand_value_i;
          res_q_d   = '0;
          res_den_d = '0;
          if (operand_value_i == 32'sd0) begin
            res_err_d = ERR_ZERO_GRAD;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_H_CHK;
          end
        end
      end
      ST_H_CHK: begin
        h_d = col_rd_q;
        if (col_rd_q[31] || col_rd_q == 32'd0) begin
          res_err_d = ERR_BAD_H22;
          state_d   = ST_DONE;
        end else begin
          sq_x_d   = {col_rd_q, 32'd0};
          sq_res_d = '0;
          sq_bit_d = 64'h4000_0000_0000_0000;
          sq_cnt_d = '0;
          state_d  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_x_q >= sq_trial) begin
          sq_x_d   = sq_x_q - sq_trial;
          sq_res_d = (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        sq_cnt_d = sq_cnt_q + 1'b1;
        if (sq_cnt_q == 5'd31) begin
          r_d   = sq_res_d[31:0];
          i_d   = '0;
          sum_d = '0;
          // an empty factor leaves the norm at zero
          state_d = (n_q == '0) ? ST_DEN : ST_V_RD;
        end
      end
      ST_V_RD: begin
        state_d = ST_V_GO;
      end
      ST_V_GO: begin
        div_start = 1'b1;
        div_num   = {24'd0, mag32(col_rd_q), 40'd0};
        div_den   = {32'd0, r_q};
        neg_d     = col_rd_q[31];
        state_d   = ST_V_DIV;
      end
      ST_V_DIV: begin
        if (div_done) begin
          wrk_we    = 1'b1;
          wrk_wdata = neg_q ? (48'd0 - div_quo) : div_quo;
          if (i_q + 1'b1 == n_q) begin
            i_d     = '0;
            j_d     = '0;
            sum_d   = '0;
            state_d = ST_F_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_V_RD;
          end
        end
      end
      ST_F_RD: begin
        state_d = ST_F_GO;
      end
      ST_F_GO: begin
        if (j_q < i_q) begin
          // off-diagonal term L[i][j]*u[j]
          mul_start = 1'b1;
          mul_a     = {16'd0, mag32(fac_rd_q)};
          mul_b     = mag48(wrk_rd_q);
          neg_d     = fac_rd_q[31] ^ wrk_rd_q[WORK_W-1];
          state_d   = ST_F_MUL;
        end else if (fac_rd_q == 32'd0) begin
          res_err_d = ERR_ZERO_PIVOT;
          state_d   = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = {16'd0, mag64(num_s), 16'd0};
          div_den   = {32'd0, mag32(fac_rd_q)};
          neg_d     = num_s[63] ^ fac_rd_q[31];
          state_d   = ST_U_DIV;
        end
      end
      ST_F_MUL: begin
        if (mul_done) begin
          if ($signed(acc_sum) > $signed(SUM_LIM)) begin
            sum_d = SUM_LIM;
          end else if ($signed(acc_sum) < -$signed(SUM_LIM)) begin
            sum_d = 64'd0 - SUM_LIM;
          end else begin
            sum_d = acc_sum;
          end
          j_d     = j_q + 1'b1;
          state_d = ST_F_RD;
        end
      end
      ST_U_DIV: begin
        if (div_done) begin
          wrk_we    = 1'b1;
          wrk_wdata = neg_q ? (48'd0 - div_quo) : div_quo;
          j_d       = '0;
          sum_d     = '0;
          if (i_q + 1'b1 == n_q) begin
            i_d     = '0;
            state_d = ST_N_RD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_F_RD;
          end
        end
      end
      ST_N_RD: begin
        state_d = ST_N_GO;
      end
      ST_N_GO: begin
        mul_start = 1'b1;
        mul_a     = mag48(wrk_rd_q);
        mul_b     = mag48(wrk_rd_q);
        state_d   = ST_N_MUL;
      end
      ST_N_MUL: begin
        if (mul_done) begin
          sum_d = (acc_sum > SUM_LIM) ? SUM_LIM : acc_sum;
          if (i_q + 1'b1 == n_q) begin
            state_d = ST_DEN;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_N_RD;
          end
        end
      end
      ST_DEN: begin
        res_den_d = den_clip;
        d32_d     = d32_s[32:0];
        if (d32_s[63] || d32_s == 64'd0) begin
          res_err_d = ERR_BAD_DEN;
          state_d   = ST_DONE;
        end else begin
          mul_start = 1'b1;
          mul_a     = {16'd0, mag32(g_q)};
          mul_b     = {16'd0, mag32(g_q)};
          state_d   = ST_G_MUL;
        end
      end
      ST_G_MUL: begin
        if (mul_done) begin
          gg_d      = mul_prod[63:0];
          mul_start = 1'b1;
          mul_a     = {16'd0, h_q};
          mul_b     = {15'd0, d32_q};
          state_d   = ST_HD_MUL;
        end
      end
      ST_HD_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = {gg_q, 32'd0};
          div_den   = mul_prod[63:0];
          div_lim   = Q_LIM;
          state_d   = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        if (div_done) begin
          res_q_d   = div_quo[30:0];
          res_err_d = ERR_OK;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_q_d     = out_q_q;
    out_den_d   = out_den_q;
    out_err_d   = out_err_q;
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_q_d     = res_q_q;
      out_den_d   = res_den_q;
      out_err_d   = res_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dim_q       <= 5'(MAX_ORDER);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    i_q       <= i_d;
    j_q       <= j_d;
    g_q       <= g_d;
    h_q       <= h_d;
    r_q       <= r_d;
    sum_q     <= sum_d;
    gg_q      <= gg_d;
    d32_q     <= d32_d;
    neg_q     <= neg_d;
    sq_x_q    <= sq_x_d;
    sq_res_q  <= sq_res_d;
    sq_bit_q  <= sq_bit_d;
    sq_cnt_q  <= sq_cnt_d;
    res_q_q   <= res_q_d;
    res_den_q <= res_den_d;
    res_err_q <= res_err_d;
    out_q_q   <= out_q_d;
    out_den_q <= out_den_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign q_statistic_o = out_q_q;
  assign denominator_o = out_den_q;
  assign error_code_o  = out_err_q;

  // shared units are only started when free
  a_div_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mul_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_mul_done_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_F_MUL || state_q == ST_N_MUL ||
                  state_q == ST_G_MUL || state_q == ST_HD_MUL))
    else $error("multiplier result with no state waiting for it");

  a_early_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o == ERR_ZERO_GRAD || error_code_o == ERR_BAD_H22 ||
                     error_code_o == ERR_ZERO_PIVOT))
    |-> (q_statistic_o == '0 && denominator_o == '0))
    else $error("early error with nonzero payload");

  a_ok_den_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o == ERR_OK) |-> !denominator_o[31])
    else $error("ok result with negative denominator");

endmodule

`default_nettype wire

>>> tb/score_statistic_triangular_solve_tb.sv
// score_statistic_triangular_solve_tb: self-checking bench for the score statistic block
// depends on sst_pkg and score_statistic_triangular_solve
// queue-fed driver, clocked monitor, in-bench fixed-point prediction of each compute result
`default_nettype none

module score_statistic_triangular_solve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  localparam logic [1:0]  OP_RESERVED = 2'd3;
  localparam int          IDLE_PCT    = 26;
  localparam int          STALL_LIMIT = 40000;  // cycles with no transaction on either side
  localparam logic [63:0] SAT_47      = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SAT_62      = 64'h4000_0000_0000_0000;
  localparam logic [63:0] SAT_Q       = 64'h0000_0000_7FFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  row;
    logic [3:0]  col;
    logic [31:0] val;
  } req_t;

  typedef struct {
    logic [30:0] q;
    logic [31:0] den;
    err_e        err;
  } score_t;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  opcode_i;
  logic [4:0]  row_index_i;
  logic [3:0]  col_index_i;
  logic [31:0] operand_value_i;
  logic        out_valid_o, out_stall_i;
  logic [30:0] q_statistic_o;
  logic [31:0] denominator_o;
  logic [2:0]  error_code_o;

  score_statistic_triangular_solve u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .operand_value_i(operand_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .q_statistic_o  (q_statistic_o),
    .denominator_o  (denominator_o),
    .error_code_o   (error_code_o)
  );

  // pending requests and scores still owed by the block
  req_t   req_q[$];
  score_t score_q[$];
  int     fail_count = 0;
  bit     calm = 0;          // no idling on either side while set
  int     quiet_cycles = 0;

  // mirror of the block state
  logic [31:0] factor_m[MAX_ORDER][MAX_ORDER];
  logic [31:0] column_m[MAX_ORDER+1];
  longint      solve_v[MAX_ORDER];
  logic [4:0]  order_m;

  // ---------------------------------------------------------------------------
  // fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_sum(input longint v);
    longint b;
    b = longint'(SAT_62);
    return v > b ? b : (v < -b ? -b : v);
  endfunction

  // bitwise integer square root
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else res = res >> 1;
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(a*b / 2^s), capped
  function automatic logic [63:0] mul_shr(input logic [63:0] a, b, input int s,
                                          input logic [63:0] limit);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return p > {64'd0, limit} ? limit : p[63:0];
  endfunction

  // floor(num * 2^s / den), capped
  function automatic logic [63:0] div_shl(input logic [63:0] num, den, input int s,
                                          input logic [63:0] limit);
    logic [127:0] t;
    t = ({64'd0, num} << s) / {64'd0, den};
    return t > {64'd0, limit} ? limit : t[63:0];
  endfunction

  // score for one compute transaction, updates the solve vector like the block
  function automatic score_t score_of(input logic [31:0] grad_raw);
    score_t      e;
    int          n;
    longint      g, h, b, l, t, sum, piv, num, d32, den16;
    logic [63:0] r, v, u, gm;
    e.q = '0; e.den = '0; e.err = ERR_OK;
    n = order_m > MAX_ORDER ? MAX_ORDER : order_m;
    g = longint'($signed(grad_raw));
    if (g == 0) begin
      e.err = ERR_ZERO_GRAD;
      return e;
    end
    h = longint'($signed(column_m[n]));
    if (h <= 0) begin
      e.err = ERR_BAD_H22;
      return e;
    end
    r = int_sqrt(64'(h) << 32);
    // scaled column
    for (int i = 0; i < n; i++) begin
      b = longint'($signed(column_m[i]));
      v = div_shl(mag(b), r, 40, SAT_47);
      solve_v[i] = b < 0 ? -longint'(v) : longint'(v);
    end
    // forward substitution
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < i; j++) begin
        l = longint'($signed(factor_m[i][j]));
        t = longint'(mul_shr(mag(l), mag(solve_v[j]), 16, SAT_62));
        if ((l < 0) != (solve_v[j] < 0)) t = -t;
        sum = clamp_sum(sum + t);
      end
      piv = longint'($signed(factor_m[i][i]));
      if (piv == 0) begin
        e.err = ERR_ZERO_PIVOT;
        return e;
      end
      num = solve_v[i] - sum;
      u = div_shl(mag(num), mag(piv), 16, SAT_47);
      solve_v[i] = ((num < 0) != (piv < 0)) ? -longint'(u) : longint'(u);
    end
    // squared norm and denominator
    sum = 0;
    for (int i = 0; i < n; i++)
      sum = clamp_sum(sum + longint'(mul_shr(mag(solve_v[i]), mag(solve_v[i]), 32, SAT_62)));
    d32 = (longint'(1) << 32) - sum;
    if (d32 >= 0) den16 = d32 >>> 16;
    else den16 = -longint'((mag(d32) + 64'hFFFF) >> 16);
    if (den16 < -longint'(64'h8000_0000)) den16 = -longint'(64'h8000_0000);
    e.den = den16[31:0];
    if (d32 <= 0) begin
      e.err = ERR_BAD_DEN;
      return e;
    end
    gm = mag(g);
    e.q = 31'(div_shl(gm * gm, 64'(h) * 64'(d32), 32, SAT_Q));
    return e;
  endfunction

  // effect of one accepted transaction on the mirror
  task automatic apply_req(input req_t rq);
    case (rq.op)
      OP_LOAD_FACTOR: begin
        if (rq.row < MAX_ORDER) factor_m[rq.row[3:0]][rq.col] = rq.val;
      end
      OP_LOAD_COLUMN: begin
        if (rq.row <= MAX_ORDER) column_m[rq.row] = rq.val;
      end
      OP_COMPUTE: score_q.push_back(score_of(rq.val));
      default: ;  // reserved opcode does nothing
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock, driver, monitor, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver: holds a stalled transaction, otherwise idles at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_req(req_q[0]);
        void'(req_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (req_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i      <= 1'b1;
          opcode_i        <= req_q[0].op;
          row_index_i     <= req_q[0].row;
          col_index_i     <= req_q[0].col;
          operand_value_i <= req_q[0].val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and field-by-field compare
  always @(posedge clk_i) begin
    score_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (score_q.size() == 0) begin
          report("unexpected result", {1'b0, q_statistic_o}, '0);
        end else begin
          want = score_q.pop_front();
          if (q_statistic_o !== want.q) report("q_statistic", {1'b0, q_statistic_o}, {1'b0, want.q});
          if (denominator_o !== want.den) report("denominator", denominator_o, want.den);
          if (error_code_o !== want.err) report("error_code", {29'd0, error_code_o},
                                                {29'd0, want.err});
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put(input logic [1:0] op, input int row, input int col, input logic [31:0] val);
    req_t rq;
    rq.op = op; rq.row = row[4:0]; rq.col = col[3:0]; rq.val = val;
    req_q.push_back(rq);
  endtask

  // all submitted work done, then wait so the block is idle
  task automatic drain();
    while (req_q.size() != 0 || in_valid_i || score_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_order(input logic [4:0] n);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_m = n;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] signed_rand(input int span);
    int m;
    m = $urandom_range(span);
    return $urandom_range(1) ? 32'(-m) : 32'(m);
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // well-conditioned factor and column, then one compute with random gradient
  task automatic system_seq(input int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++)
        if (i == j) put(OP_LOAD_FACTOR, i, j, $urandom_range(1) ?
                        32'(65536 + $urandom_range(196608)) :
                        32'(-(65536 + $urandom_range(196608))));
        else put(OP_LOAD_FACTOR, i, j, signed_rand(8192));
    for (int i = 0; i < n; i++)
      put(OP_LOAD_COLUMN, i, 0, signed_rand($urandom_range(3) == 0 ? 65536 : 12288));
    put(OP_LOAD_COLUMN, n, 0, $urandom_range(7) == 0 ? 32'($urandom_range(65535)) :
        32'(65536 + $urandom_range(458752)));
    case ($urandom_range(3))
      0: put(OP_COMPUTE, 0, 0, $urandom);
      1: put(OP_COMPUTE, 0, 0, any_word());
      default: put(OP_COMPUTE, 0, 0, signed_rand(1048576));
    endcase
  endtask

  // anything goes: random opcode, indexes and values
  task automatic noise_item();
    put(2'($urandom_range(3)), $urandom_range(31), $urandom_range(15), any_word());
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [4:0] orders[10];
    int         n, quota;
    orders = '{5'd1, 5'd3, 5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd8, 5'd4, 5'd12};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; opcode_i = '0; row_index_i = '0; col_index_i = '0;
    operand_value_i = '0; out_stall_i = 1'b0;
    order_m = 5'd16;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the lower triangle and the column once so nothing is ever read unwritten
    for (int i = 0; i < MAX_ORDER; i++)
      for (int j = 0; j <= i; j++)
        put(OP_LOAD_FACTOR, i, j, i == j ? 32'h0001_0000 : 32'h0000_0000);
    for (int i = 0; i < MAX_ORDER; i++) put(OP_LOAD_COLUMN, i, 0, 32'h0000_1000);
    put(OP_LOAD_COLUMN, MAX_ORDER, 0, 32'h0001_0000);

    // directed: reset order, gradient extremes, zero gradient, ignored loads
    put(OP_COMPUTE, 0, 0, 32'h7FFF_FFFF);
    put(OP_COMPUTE, 0, 0, 32'h8000_0000);
    put(OP_COMPUTE, 0, 0, 32'h0000_0000);
    put(OP_RESERVED, 31, 15, 32'hFFFF_FFFF);
    put(OP_LOAD_FACTOR, 16, 0, 32'h7FFF_FFFF);
    put(OP_LOAD_FACTOR, 31, 15, 32'h8000_0000);
    put(OP_LOAD_COLUMN, 17, 0, 32'h8000_0000);
    put(OP_LOAD_COLUMN, 31, 15, 32'h7FFF_FFFF);
    put(OP_COMPUTE, 0, 0, 32'h0000_0001);

    // directed at order 2 with identity factor: negative denominator, bad h22, zero pivot
    set_order(5'd2);
    put(OP_LOAD_COLUMN, 0, 0, 32'd65535);
    put(OP_LOAD_COLUMN, 1, 0, 32'd256);
    put(OP_COMPUTE, 0, 0, 32'h0001_0000);       // negative denominator
    put(OP_LOAD_COLUMN, 0, 0, 32'd65536);
    put(OP_LOAD_COLUMN, 1, 0, 32'd0);
    put(OP_COMPUTE, 0, 0, 32'h0001_0000);       // negative denominator
    put(OP_LOAD_COLUMN, 0, 0, 32'h7FFF_FFFF);
    put(OP_COMPUTE, 0, 0, 32'hFFFF_0000);       // strongly negative denominator
    put(OP_LOAD_COLUMN, 2, 0, 32'h0000_0000);
    put(OP_COMPUTE, 0, 0, 32'h0000_1000);       // h22 zero
    put(OP_LOAD_COLUMN, 2, 0, 32'h8000_0000);
    put(OP_COMPUTE, 0, 0, 32'h0000_1000);       // h22 negative
    put(OP_LOAD_COLUMN, 2, 0, 32'h0001_0000);
    put(OP_LOAD_FACTOR, 1, 1, 32'h0000_0000);
    put(OP_COMPUTE, 0, 0, 32'h0000_1000);       // zero pivot on the second row
    put(OP_LOAD_FACTOR, 1, 1, 32'h0001_0000);

    // random phases over several orders, mostly small
    foreach (orders[p]) begin
      set_order(orders[p]);
      calm = (p == 2);                          // one phase runs without any idling
      n = orders[p] > MAX_ORDER ? MAX_ORDER : orders[p];
      quota = 30;
      while (quota > 0) begin
        if ($urandom_range(9) < 7) begin
          system_seq(n);
          quota -= n * (n + 1) / 2 + n + 2;
        end else begin
          noise_item();
          quota--;
        end
        // sender holds off until the block has caught up
        if (p == 1 && quota < 20 && quota >= 9) drain();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
